### hw/rtl/gvecho_pkg.sv
// shared types and constants of the two-grain voice with echo
// no dependencies
package gvecho_pkg;

    localparam int ECHO_DEPTH = 2048;
    localparam int ECHO_AW = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;

    localparam logic [15:0] GRAIN_RESTART_AMP = 16'h7fff;
    localparam logic [7:0] SAMPLE_MAX = 8'hff;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // one classified word handed from the front to the back
    typedef struct packed {
        logic [7:0] first_tri;
        logic [7:0] first_amp_hi;
        logic [7:0] second_tri;
        logic [7:0] second_amp_hi;
        logic       grain_restarted;
        logic       echo_enable;
    } queue_word_t;

endpackage

### hw/rtl/gvecho_if.sv
// valid/ready channels of the two-grain voice with echo
// no dependencies
interface gvecho_tick_if;
    logic        valid;
    logic        ready;
    logic [15:0] sync_increment;
    logic [15:0] first_grain_increment;
    logic [7:0]  first_grain_decay;
    logic [15:0] second_grain_increment;
    logic [7:0]  second_grain_decay;
    logic        echo_enable;

    modport source (
        output valid, sync_increment, first_grain_increment, first_grain_decay,
               second_grain_increment, second_grain_decay, echo_enable,
        input  ready
    );
    modport sink (
        input  valid, sync_increment, first_grain_increment, first_grain_decay,
               second_grain_increment, second_grain_decay, echo_enable,
        output ready
    );
endinterface

interface gvecho_sound_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_value;
    logic       grain_restarted;

    modport source (output valid, sample_value, grain_restarted, input ready);
    modport sink (input valid, sample_value, grain_restarted, output ready);
endinterface

### hw/rtl/gvecho_front.sv
// front: oscillator and envelope state, classifies each tick into a queue word
// depends on gvecho_pkg and gvecho_if
module gvecho_front
    import gvecho_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    gvecho_tick_if.sink         tick,
    input  logic                queue_full,
    output logic                push,
    output queue_word_t         push_word
);

    logic [15:0] sync_phase_reg, sync_phase_next;
    logic [15:0] first_phase_reg, first_phase_next;
    logic [15:0] second_phase_reg, second_phase_next;
    logic [15:0] first_amp_reg, first_amp_next;
    logic [15:0] second_amp_reg, second_amp_next;

    logic [16:0] sync_sum;
    logic        carry;
    logic [15:0] first_amp_cur, second_amp_cur;
    logic [15:0] first_drop, second_drop;

    assign tick.ready = !queue_full;
    assign push = tick.valid && !queue_full;

    always_comb
    begin
        sync_sum = {1'b0, sync_phase_reg} + {1'b0, tick.sync_increment};
        carry = sync_sum[16];
        sync_phase_next = sync_sum[15:0];

        first_phase_next = (carry ? 16'h0000 : first_phase_reg) + tick.first_grain_increment;
        second_phase_next = (carry ? 16'h0000 : second_phase_reg) + tick.second_grain_increment;

        first_amp_cur = carry ? GRAIN_RESTART_AMP : first_amp_reg;
        second_amp_cur = carry ? GRAIN_RESTART_AMP : second_amp_reg;

        first_drop = first_amp_cur[15:8] * tick.first_grain_decay;
        second_drop = second_amp_cur[15:8] * tick.second_grain_decay;
        first_amp_next = first_amp_cur - first_drop;
        second_amp_next = second_amp_cur - second_drop;

        // triangle from phase bits 14..7, folded while bit 15 is set
        push_word.first_tri = first_phase_next[15] ? ~first_phase_next[14:7]
                                                   : first_phase_next[14:7];
        push_word.second_tri = second_phase_next[15] ? ~second_phase_next[14:7]
                                                     : second_phase_next[14:7];
        push_word.first_amp_hi = first_amp_cur[15:8];
        push_word.second_amp_hi = second_amp_cur[15:8];
        push_word.grain_restarted = carry;
        push_word.echo_enable = tick.echo_enable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_phase_reg <= '0;
            first_phase_reg <= '0;
            second_phase_reg <= '0;
            first_amp_reg <= '0;
            second_amp_reg <= '0;
        end
        else if (push)
        begin
            sync_phase_reg <= sync_phase_next;
            first_phase_reg <= first_phase_next;
            second_phase_reg <= second_phase_next;
            first_amp_reg <= first_amp_next;
            second_amp_reg <= second_amp_next;
        end
    end

endmodule

### hw/rtl/gvecho_queue.sv
// short queue of classified words between front and back
// depends on gvecho_pkg
module gvecho_queue
    import gvecho_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  queue_word_t push_word,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output queue_word_t head_word
);

    queue_word_t slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/gvecho_back.sv
// back: grain products, mix, echo line and output register
// depends on gvecho_pkg and gvecho_if
module gvecho_back
    import gvecho_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         not_empty,
    input  queue_word_t  head_word,
    output logic         pop,
    gvecho_sound_if.source sound
);

    logic [7:0] echo_mem [ECHO_DEPTH];

    // product stage
    logic        s1_valid_reg;
    logic [15:0] first_prod_reg, second_prod_reg;
    logic        s1_restarted_reg, s1_echo_reg;
    logic [7:0]  echo_q_reg;
    logic        echo_q_valid_reg;

    // echo pointers; entries ahead of the read pointer before its first wrap read as zero
    logic [ECHO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic               rd_wrapped_reg, rd_wrapped_next;
    logic [ECHO_AW-1:0] wr_ptr_reg, wr_ptr_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] sample_reg;
    logic       restarted_reg;

    logic       s1_load, s2_load, echo_write;
    logic [15:0] mix_sum;
    logic [7:0]  dry, echo_val, wet;
    logic [8:0]  avg_sum;

    assign s2_load = s1_valid_reg && (!out_valid_reg || sound.ready);
    assign s1_load = not_empty && (!s1_valid_reg || s2_load);
    assign pop = s1_load;
    assign echo_write = s2_load && s1_echo_reg;

    always_comb
    begin
        mix_sum = first_prod_reg + second_prod_reg;
        dry = (mix_sum[15:9] > SAMPLE_MAX[6:0] && 1'b0) ? SAMPLE_MAX : {1'b0, mix_sum[15:9]};
        echo_val = echo_q_valid_reg ? echo_q_reg : 8'h00;
        avg_sum = {1'b0, dry} + {1'b0, echo_val};
        wet = s1_echo_reg ? avg_sum[8:1] : dry;

        rd_ptr_next = rd_ptr_reg;
        rd_wrapped_next = rd_wrapped_reg;
        if (s1_load && head_word.echo_enable)
        begin
            if (rd_ptr_reg == ECHO_AW'(ECHO_DEPTH-1))
            begin
                rd_ptr_next = '0;
                rd_wrapped_next = 1'b1;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end

        wr_ptr_next = wr_ptr_reg;
        if (echo_write)
        begin
            wr_ptr_next = (wr_ptr_reg == ECHO_AW'(ECHO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (echo_write)
        begin
            echo_mem[wr_ptr_reg] <= wet;
        end
        if (s1_load)
        begin
            echo_q_reg <= echo_mem[rd_ptr_reg];
            echo_q_valid_reg <= rd_wrapped_reg;
            first_prod_reg <= head_word.first_tri * head_word.first_amp_hi;
            second_prod_reg <= head_word.second_tri * head_word.second_amp_hi;
            s1_restarted_reg <= head_word.grain_restarted;
            s1_echo_reg <= head_word.echo_enable;
        end
        if (s2_load)
        begin
            sample_reg <= wet;
            restarted_reg <= s1_restarted_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_ptr_reg <= '0;
            rd_wrapped_reg <= 1'b0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sound.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_ptr_reg <= rd_ptr_next;
            rd_wrapped_reg <= rd_wrapped_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    assign sound.valid = out_valid_reg;
    assign sound.sample_value = sample_reg;
    assign sound.grain_restarted = restarted_reg;

endmodule

### hw/rtl/granular_two_grain_voice_echo.sv
// Two-grain granular voice with echo: takes one tick word per clock cycle
// while the queue is not full and returns one sample word per tick. The rate
// is set by the oscillator and envelope update in the front, which closes its
// loop combinationally between its state registers (one 8x8 multiply per
// grain); a two-word queue and a two-stage back end (grain products, then mix
// and echo) let either side stall on its own. The echo line is one 2048 x 8
// memory with one read and one write port; it needs no clearing pass, since a
// wrap flag makes entries that were never written read as zero.
// depends on gvecho_pkg, gvecho_if, gvecho_front, gvecho_queue, gvecho_back
module granular_two_grain_voice_echo
    import gvecho_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    gvecho_tick_if.sink    tick,
    gvecho_sound_if.source sound
);

    logic        push, pop, queue_full, queue_not_empty;
    queue_word_t push_word, head_word;

    gvecho_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .queue_full (queue_full),
        .push       (push),
        .push_word  (push_word)
    );

    gvecho_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_word (head_word)
    );

    gvecho_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (queue_not_empty),
        .head_word (head_word),
        .pop       (pop),
        .sound     (sound)
    );

endmodule
